>>> rtl/core/oarc_pkg.sv
`default_nettype none

package oarc_pkg;

  // Counter geometry
  localparam int MaxSlots = 32;
  localparam int OtpWords = 1024;

  // Field widths
  localparam int AddrW   = 10;
  localparam int CountW  = 6;
  localparam int WordW   = 16;
  localparam int TargetW = 32;

  // Width of first word plus slot before the fold into the OTP word range
  localparam int SumW = $clog2(2 * OtpWords + 1);

  localparam logic [WordW-1:0] SLOT_MARKER = 16'hC35A;
  localparam logic [WordW-1:0] SLOT_EMPTY  = 16'h0000;

  // Register reset values
  localparam logic [AddrW-1:0]  SEC_FIRST_RST   = 10'd304;
  localparam logic [CountW-1:0] SEC_COUNT_RST   = 6'd24;
  localparam logic [AddrW-1:0]  NSEC_FIRST_RST  = 10'd328;
  localparam logic [CountW-1:0] NSEC_COUNT_RST  = 6'd24;

  typedef enum logic [1:0] {
    CFG_SEC_FIRST  = 2'd0,
    CFG_SEC_COUNT  = 2'd1,
    CFG_NSEC_FIRST = 2'd2,
    CFG_NSEC_COUNT = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    CMD_GET       = 3'd0,
    CMD_SET       = 3'd1,
    CMD_RD_RESP   = 3'd2,
    CMD_PROG_DONE = 3'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SCAN   = 2'd1,
    PH_PROG   = 2'd2,
    PH_VERIFY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_PROG = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPARAM = 3'd1,
    ST_SECURITY = 3'd2,
    ST_OTPERR   = 3'd3,
    ST_BUSY     = 3'd4,
    ST_UNSUP    = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               bank;
    logic [TargetW-1:0] target;
    logic [WordW-1:0]   otp_data;
    logic               otp_error;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [AddrW-1:0]  otp_address;
    logic [WordW-1:0]  otp_write_data;
    logic [CountW-1:0] counter;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic [AddrW-1:0]  sec_first;
    logic [CountW-1:0] sec_count;
    logic [AddrW-1:0]  nsec_first;
    logic [CountW-1:0] nsec_count;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/otp_anti_rollback_counter_controller.sv
`default_nettype none

// Sequencer for two thermometer-coded anti-rollback counters kept in OTP
// (bank 0 secure, bank 1 non-secure). Each transfer on the in_ side is one
// event: a get or set command, an OTP read response or an OTP program-done.
// Each event gives at most one out_ transfer: an OTP read request, an OTP
// program request (always the slot marker 0xC35A) or a command completion
// with counter and status. The block takes one event per clock while the
// result register can take a result: an event is held in the input register
// while the step logic updates the sequencer state and loads the result
// register, from which the result is offered on out_. The sustained rate
// is one event per cycle as long as out_tready is high. Only a stalled
// result register holds back the next event. Write the slot-range registers
// through the cfg_ port only while no command is in progress.
module otp_anti_rollback_counter_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // bank[0], target[32:1], otp_data[48:33], otp_error[49]
  input  wire logic [2:0]  in_tuser,   // cmd[2:0]

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // otp_address[9:0], otp_write_data[25:10],
                                       // counter[31:26], status[34:32]
  output logic [1:0]       out_tuser,  // kind[1:0]

  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata
);

  oarc_pkg::cfg_t    cfg_r;
  oarc_pkg::item_t   item;
  oarc_pkg::result_t res;
  logic              item_valid;
  logic              res_valid;
  logic              out_free;
  logic              advance;

  // Step one event when it is present and the result register can take it
  assign advance = item_valid && out_free;

  // Slot-range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sec_first  <= oarc_pkg::SEC_FIRST_RST;
      cfg_r.sec_count  <= oarc_pkg::SEC_COUNT_RST;
      cfg_r.nsec_first <= oarc_pkg::NSEC_FIRST_RST;
      cfg_r.nsec_count <= oarc_pkg::NSEC_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        oarc_pkg::CFG_SEC_FIRST:  cfg_r.sec_first  <= cfg_wdata;
        oarc_pkg::CFG_SEC_COUNT:  cfg_r.sec_count  <= cfg_wdata[oarc_pkg::CountW-1:0];
        oarc_pkg::CFG_NSEC_FIRST: cfg_r.nsec_first <= cfg_wdata;
        oarc_pkg::CFG_NSEC_COUNT: cfg_r.nsec_count <= cfg_wdata[oarc_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  oarc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  oarc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  oarc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res_valid  (res_valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

>>> rtl/core/oarc_in_stage.sv
`default_nettype none

module oarc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [55:0]    in_tdata,  // bank, target, otp_data, otp_error
  input  wire logic [2:0]     in_tuser,  // cmd
  input  wire logic           take,
  output logic                item_valid,
  output oarc_pkg::item_t     item
);

  logic            valid_r;
  oarc_pkg::item_t item_r;
  oarc_pkg::item_t item_nxt;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.cmd       = in_tuser;
    item_nxt.bank      = in_tdata[0];
    item_nxt.target    = in_tdata[32:1];
    item_nxt.otp_data  = in_tdata[48:33];
    item_nxt.otp_error = in_tdata[49];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/oarc_seq.sv
`default_nettype none

module oarc_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire oarc_pkg::item_t item,
  input  wire oarc_pkg::cfg_t  cfg,
  output logic                 res_valid,
  output oarc_pkg::result_t    res
);

  localparam logic [oarc_pkg::SumW-1:0] Words1 = oarc_pkg::SumW'(oarc_pkg::OtpWords);
  localparam logic [oarc_pkg::SumW-1:0] Words2 = oarc_pkg::SumW'(2 * oarc_pkg::OtpWords);
  localparam logic [oarc_pkg::CountW:0] MaxCnt = (oarc_pkg::CountW + 1)'(oarc_pkg::MaxSlots);

  oarc_pkg::phase_t                phase_r, phase_nxt;
  logic                            op_is_set_r, op_is_set_nxt;
  logic [oarc_pkg::AddrW-1:0]      base_r, base_nxt;
  logic [oarc_pkg::CountW-1:0]     count_r, count_nxt;
  logic [oarc_pkg::CountW-1:0]     idx_r, idx_nxt;
  logic [oarc_pkg::CountW-1:0]     tgt_r, tgt_nxt;

  logic [oarc_pkg::AddrW-1:0]      sel_base;
  logic [oarc_pkg::CountW-1:0]     sel_count;
  logic [oarc_pkg::CountW-1:0]     eff_count;
  logic [oarc_pkg::CountW-1:0]     idx_inc;
  logic [oarc_pkg::CountW-1:0]     found;

  // Fold first word plus slot into the OTP word range
  function automatic logic [oarc_pkg::AddrW-1:0] slot_addr(
    input logic [oarc_pkg::AddrW-1:0]  base,
    input logic [oarc_pkg::CountW-1:0] slot
  );
    logic [oarc_pkg::SumW-1:0] sum;
    sum = oarc_pkg::SumW'(base) + oarc_pkg::SumW'(slot);
    if (sum >= Words2) begin
      sum = sum - Words2;
    end else if (sum >= Words1) begin
      sum = sum - Words1;
    end
    return sum[oarc_pkg::AddrW-1:0];
  endfunction

  always_comb begin
    sel_base  = item.bank ? cfg.nsec_first : cfg.sec_first;
    sel_count = item.bank ? cfg.nsec_count : cfg.sec_count;
    if ({1'b0, sel_count} > MaxCnt) begin
      eff_count = MaxCnt[oarc_pkg::CountW-1:0];
    end else begin
      eff_count = sel_count;
    end
    idx_inc = idx_r + 1'b1;
    found   = (item.otp_data == oarc_pkg::SLOT_EMPTY) ? idx_r : idx_inc;
  end

  always_comb begin
    phase_nxt     = phase_r;
    op_is_set_nxt = op_is_set_r;
    base_nxt      = base_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    res_valid     = 1'b0;
    res           = '{kind: oarc_pkg::KIND_DONE, otp_address: '0, otp_write_data: '0,
                      counter: '0, status: oarc_pkg::ST_OK};

    case (item.cmd)
      oarc_pkg::CMD_GET, oarc_pkg::CMD_SET: begin
        res_valid = 1'b1;
        if (phase_r != oarc_pkg::PH_IDLE) begin
          res.status = oarc_pkg::ST_BUSY;
        end else if ((item.cmd == oarc_pkg::CMD_SET &&
                      item.target > oarc_pkg::TargetW'(eff_count)) ||
                     eff_count == '0) begin
          res.status = oarc_pkg::ST_BADPARAM;
        end else begin
          op_is_set_nxt   = (item.cmd == oarc_pkg::CMD_SET);
          base_nxt        = sel_base;
          count_nxt       = eff_count;
          idx_nxt         = '0;
          tgt_nxt         = (item.cmd == oarc_pkg::CMD_SET) ?
                            item.target[oarc_pkg::CountW-1:0] : '0;
          phase_nxt       = oarc_pkg::PH_SCAN;
          res.kind        = oarc_pkg::KIND_READ;
          res.otp_address = slot_addr(sel_base, '0);
        end
      end

      oarc_pkg::CMD_RD_RESP: begin
        if (phase_r == oarc_pkg::PH_SCAN) begin
          res_valid = 1'b1;
          if (item.otp_error) begin
            phase_nxt  = oarc_pkg::PH_IDLE;
            res.status = oarc_pkg::ST_OTPERR;
          end else if (item.otp_data != oarc_pkg::SLOT_EMPTY &&
                       item.otp_data != oarc_pkg::SLOT_MARKER) begin
            phase_nxt  = oarc_pkg::PH_IDLE;
            res.status = oarc_pkg::ST_SECURITY;
          end else begin
            idx_nxt = found;
            if (item.otp_data == oarc_pkg::SLOT_EMPTY || idx_inc >= count_r) begin
              // Scan finished: report, or start programming missing slots
              if (!op_is_set_r || tgt_r <= found) begin
                phase_nxt   = oarc_pkg::PH_IDLE;
                res.counter = found;
              end else begin
                phase_nxt          = oarc_pkg::PH_PROG;
                res.kind           = oarc_pkg::KIND_PROG;
                res.otp_address    = slot_addr(base_r, found);
                res.otp_write_data = oarc_pkg::SLOT_MARKER;
              end
            end else begin
              res.kind        = oarc_pkg::KIND_READ;
              res.otp_address = slot_addr(base_r, idx_inc);
            end
          end
        end else if (phase_r == oarc_pkg::PH_VERIFY) begin
          res_valid = 1'b1;
          if (item.otp_error) begin
            phase_nxt  = oarc_pkg::PH_IDLE;
            res.status = oarc_pkg::ST_OTPERR;
          end else if (item.otp_data != oarc_pkg::SLOT_MARKER) begin
            phase_nxt  = oarc_pkg::PH_IDLE;
            res.status = oarc_pkg::ST_SECURITY;
          end else begin
            idx_nxt = idx_inc;
            if (idx_inc >= tgt_r) begin
              phase_nxt   = oarc_pkg::PH_IDLE;
              res.counter = tgt_r;
            end else begin
              phase_nxt          = oarc_pkg::PH_PROG;
              res.kind           = oarc_pkg::KIND_PROG;
              res.otp_address    = slot_addr(base_r, idx_inc);
              res.otp_write_data = oarc_pkg::SLOT_MARKER;
            end
          end
        end
      end

      oarc_pkg::CMD_PROG_DONE: begin
        if (phase_r == oarc_pkg::PH_PROG) begin
          res_valid = 1'b1;
          if (item.otp_error) begin
            phase_nxt  = oarc_pkg::PH_IDLE;
            res.status = oarc_pkg::ST_OTPERR;
          end else begin
            phase_nxt       = oarc_pkg::PH_VERIFY;
            res.kind        = oarc_pkg::KIND_READ;
            res.otp_address = slot_addr(base_r, idx_r);
          end
        end
      end

      default: begin
        res_valid  = 1'b1;
        res.status = oarc_pkg::ST_UNSUP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= oarc_pkg::PH_IDLE;
      op_is_set_r <= 1'b0;
      base_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      tgt_r       <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      op_is_set_r <= op_is_set_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      tgt_r       <= tgt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != oarc_pkg::PH_IDLE |-> count_r != '0)
    else $error("sequence running with zero slot count");

  a_prog_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == oarc_pkg::PH_PROG || phase_r == oarc_pkg::PH_VERIFY)
      |-> (op_is_set_r && idx_r < tgt_r && tgt_r <= count_r))
    else $error("program phase without a pending slot below target");

  a_done_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == oarc_pkg::KIND_DONE)
      |-> (res.otp_address == '0 && res.otp_write_data == '0))
    else $error("completion carries an OTP access");

  a_fail_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != oarc_pkg::ST_OK) |-> res.counter == '0)
    else $error("failed completion reports a counter value");

  a_busy_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res_valid && res.status == oarc_pkg::ST_BUSY)
      |=> (phase_r == $past(phase_r) && idx_r == $past(idx_r)))
    else $error("busy rejection disturbed the running sequence");
`endif

endmodule

`default_nettype wire

>>> rtl/core/oarc_out_stage.sv
`default_nettype none

module oarc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              res_valid,
  input  wire oarc_pkg::result_t res,
  output logic                   free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,  // otp_address, otp_write_data, counter, status
  output logic [1:0]             out_tuser   // kind
);

  logic              valid_r;
  oarc_pkg::result_t res_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {5'b0, res_r.status, res_r.counter, res_r.otp_write_data,
                       res_r.otp_address};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_otp_anti_rollback_counter_controller.sv
`timescale 1ns / 100ps

module tb_otp_anti_rollback_counter_controller;
  import oarc_pkg::*;

  // Command codes above the defined set all complete as unsupported
  localparam logic [2:0] CMD_UNSUP_LO = 3'd4;
  localparam logic [2:0] CMD_UNSUP_HI = 3'd7;

  localparam int IN_GAP_PCT    = 15;    // chance of an idle gap before an item
  localparam int OUT_IDLE_PCT  = 25;    // chance that the receiver drops ready in a cycle
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES = 4;     // covers the input and result registers of an event
  localparam int TOTAL_EVENTS  = 1700;  // input items over the whole run

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // bank[0], target[32:1], otp_data[48:33], otp_error[49]
  logic [2:0]  in_tuser;   // cmd[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // otp_address[9:0], otp_write_data[25:10],
                           // counter[31:26], status[34:32]
  logic [1:0]  out_tuser;  // kind[1:0]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_wdata;

  otp_anti_rollback_counter_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow of the slot-range registers and of the sequencer state
  cfg_t              regs;
  phase_t            seq_phase;
  logic              seq_is_set;
  logic [AddrW-1:0]  seq_base;
  logic [CountW-1:0] seq_count;
  logic [CountW-1:0] seq_slot;
  logic [CountW-1:0] seq_target;

  // The OTP array that the bench plays; answers read and program requests
  logic [WordW-1:0] otp_mem [OtpWords];

  // Requests and completions the block still owes, oldest first
  result_t replies_due [$];

  int  mismatches   = 0;
  int  n_events     = 0;
  int  n_answered   = 0;
  int  n_results    = 0;
  int  n_settings   = 0;
  int  stall_cycles = 0;
  bit  steady;    // no idling on either side while set
  bit  hold_req;  // ask the receiver for one long hold-off

  // Free-running clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  //--------------------------------------------------------------------------
  // Sequencer prediction
  //--------------------------------------------------------------------------

  // Slot addresses fold into the 1024-word OTP range by dropping the carry
  function automatic logic [AddrW-1:0] slot_address(logic [CountW-1:0] slot);
    return seq_base + AddrW'(slot);
  endfunction

  function automatic result_t reply(kind_t k, logic [AddrW-1:0] addr,
                                    logic [WordW-1:0] data,
                                    logic [CountW-1:0] cnt, status_t st);
    result_t r;
    r.kind           = k;
    r.otp_address    = addr;
    r.otp_write_data = data;
    r.counter        = (st == ST_OK) ? cnt : '0;
    r.status         = st;
    return r;
  endfunction

  // End the running command and report its outcome
  function automatic result_t complete(logic [CountW-1:0] cnt, status_t st);
    seq_phase = PH_IDLE;
    return reply(KIND_DONE, '0, '0, cnt, st);
  endfunction

  // Mark the current slot and wait for the program to finish
  function automatic result_t program_slot();
    seq_phase = PH_PROG;
    return reply(KIND_PROG, slot_address(seq_slot), SLOT_MARKER, '0, ST_OK);
  endfunction

  // The scan has settled on the counter value in seq_slot
  function automatic result_t value_found();
    if (!seq_is_set || seq_target <= seq_slot)
      return complete(seq_slot, ST_OK);
    return program_slot();
  endfunction

  // Advance the shadow sequencer by one event; return 1 if it answers
  function automatic bit counter_step(input item_t ev, output result_t r);
    logic [AddrW-1:0]  base;
    logic [CountW-1:0] cnt;
    r = '0;
    case (ev.cmd)
      CMD_GET, CMD_SET: begin
        // A new command while one runs is turned away, state untouched
        if (seq_phase != PH_IDLE) begin
          r = reply(KIND_DONE, '0, '0, '0, ST_BUSY);
          return 1'b1;
        end
        base = ev.bank ? regs.nsec_first : regs.sec_first;
        cnt  = ev.bank ? regs.nsec_count : regs.sec_count;
        if (cnt > MaxSlots) cnt = CountW'(MaxSlots);
        if ((ev.cmd == CMD_SET && ev.target > TargetW'(cnt)) || cnt == '0) begin
          r = reply(KIND_DONE, '0, '0, '0, ST_BADPARAM);
          return 1'b1;
        end
        seq_is_set = (ev.cmd == CMD_SET);
        seq_base   = base;
        seq_count  = cnt;
        seq_slot   = '0;
        seq_target = seq_is_set ? ev.target[CountW-1:0] : '0;
        seq_phase  = PH_SCAN;
        r = reply(KIND_READ, slot_address('0), '0, '0, ST_OK);
      end
      CMD_RD_RESP: begin
        if (seq_phase == PH_SCAN) begin
          if (ev.otp_error) r = complete('0, ST_OTPERR);
          else if (ev.otp_data == SLOT_EMPTY) r = value_found();
          else if (ev.otp_data != SLOT_MARKER) r = complete('0, ST_SECURITY);
          else begin
            seq_slot = seq_slot + 1'b1;
            if (seq_slot >= seq_count) r = value_found();
            else r = reply(KIND_READ, slot_address(seq_slot), '0, '0, ST_OK);
          end
        end else if (seq_phase == PH_VERIFY) begin
          if (ev.otp_error) r = complete('0, ST_OTPERR);
          else if (ev.otp_data != SLOT_MARKER) r = complete('0, ST_SECURITY);
          else begin
            seq_slot = seq_slot + 1'b1;
            if (seq_slot >= seq_target) r = complete(seq_target, ST_OK);
            else r = program_slot();
          end
        end else begin
          return 1'b0;
        end
      end
      CMD_PROG_DONE: begin
        if (seq_phase != PH_PROG) return 1'b0;
        if (ev.otp_error) r = complete('0, ST_OTPERR);
        else begin
          seq_phase = PH_VERIFY;
          r = reply(KIND_READ, slot_address(seq_slot), '0, '0, ST_OK);
        end
      end
      default: r = reply(KIND_DONE, '0, '0, '0, ST_UNSUP);
    endcase
    return 1'b1;
  endfunction

  //--------------------------------------------------------------------------
  // Items and the sender
  //--------------------------------------------------------------------------

  function automatic item_t event_of(logic [2:0] cmd, logic bank, logic [31:0] target,
                                     logic [15:0] data, logic err);
    item_t ev;
    ev.cmd       = cmd;
    ev.bank      = bank;
    ev.target    = target;
    ev.otp_data  = data;
    ev.otp_error = err;
    return ev;
  endfunction

  // Random content in every field; the caller overrides what matters
  function automatic item_t junk_event(logic [2:0] cmd);
    return event_of(cmd, 1'($urandom_range(1)), $urandom, WordW'($urandom),
                    1'($urandom_range(1)));
  endfunction

  // Offer one item, hold it until the transfer, then predict its answer.
  // Drive at the falling edge, sample at the rising edge.
  task automatic send_event(input item_t ev);
    result_t r;
    @(negedge clk);
    if (!steady && $urandom_range(99) < IN_GAP_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, ev.otp_error, ev.otp_data, ev.target, ev.bank};
    in_tuser  <= ev.cmd;
    do @(posedge clk); while (!in_tready);
    n_events++;
    if (counter_step(ev, r)) begin
      replies_due.push_back(r);
      n_answered++;
    end
  endtask

  // Answer the request the block has just issued from the OTP array.
  // Rarely fail the access or hand back a corrupted word.
  task automatic otp_answer();
    item_t            ev;
    logic [AddrW-1:0] addr;
    addr = slot_address(seq_slot);
    if (seq_phase == PH_PROG) begin
      ev = junk_event(CMD_PROG_DONE);
      ev.otp_error = ($urandom_range(99) < 2);
      if (!ev.otp_error) otp_mem[addr] = SLOT_MARKER;
    end else begin
      ev = junk_event(CMD_RD_RESP);
      ev.otp_error = ($urandom_range(99) < 2);
      if (!ev.otp_error && $urandom_range(99) >= 2) ev.otp_data = otp_mem[addr];
    end
    send_event(ev);
  endtask

  // Noise: a get or set command (turned away as busy while one runs), an
  // unsupported code, or a response that does not fit the phase
  function automatic item_t stray_event();
    case ($urandom_range(2))
      0:       return junk_event($urandom_range(1) ? CMD_SET : CMD_GET);
      1:       return junk_event(3'($urandom_range(CMD_UNSUP_LO, CMD_UNSUP_HI)));
      default: return junk_event(seq_phase == PH_PROG ? CMD_RD_RESP : CMD_PROG_DONE);
    endcase
  endfunction

  // One get or set, carried through to completion with the OTP answering
  task automatic run_command(input int noise_pct);
    item_t             ev;
    logic [CountW-1:0] cnt;
    int                pick;
    ev   = junk_event($urandom_range(1) ? CMD_SET : CMD_GET);
    cnt  = ev.bank ? regs.nsec_count : regs.sec_count;
    pick = $urandom_range(99);
    // Mostly reachable targets, some just past the range, some anywhere
    if (pick < 80) ev.target = $urandom_range(0, cnt);
    else if (pick < 90) ev.target = cnt + $urandom_range(1, 3);
    if ($urandom_range(99) < noise_pct) send_event(stray_event());
    send_event(ev);
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) send_event(stray_event());
      else otp_answer();
    end
  endtask

  // Lay out both counters as a thermometer of random height, with an
  // occasional foreign word to trip the security check
  task automatic fill_otp();
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  addr;
    logic [CountW-1:0] cnt;
    int                level;
    for (int b = 0; b < 2; b++) begin
      base = b ? regs.nsec_first : regs.sec_first;
      cnt  = b ? regs.nsec_count : regs.sec_count;
      if (cnt > MaxSlots) cnt = CountW'(MaxSlots);
      level = $urandom_range(0, cnt);
      for (int s = 0; s < cnt; s++) begin
        addr = base + AddrW'(s);
        otp_mem[addr] = (s < level) ? SLOT_MARKER : SLOT_EMPTY;
      end
      if (cnt != '0 && $urandom_range(99) < 10) begin
        addr = base + AddrW'($urandom_range(0, cnt - 1));
        otp_mem[addr] = WordW'($urandom);
      end
    end
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold the write enable high across back-to-back writes
  task automatic write_reg(input cfg_index_t idx, input logic [9:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SEC_FIRST:  regs.sec_first  = data;
      CFG_SEC_COUNT:  regs.sec_count  = data[CountW-1:0];
      CFG_NSEC_FIRST: regs.nsec_first = data;
      CFG_NSEC_COUNT: regs.nsec_count = data[CountW-1:0];
      default: ;
    endcase
  endtask

  // Write all four slot-range registers while the block is idle
  task automatic apply_setting(input logic [9:0] sec_first, sec_count,
                               nsec_first, nsec_count);
    wait_drained();
    write_reg(CFG_SEC_FIRST, sec_first);
    write_reg(CFG_SEC_COUNT, sec_count);
    write_reg(CFG_NSEC_FIRST, nsec_first);
    write_reg(CFG_NSEC_COUNT, nsec_count);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
    fill_otp();
  endtask

  // Mostly small counters to keep scans short; zero and oversized too
  function automatic logic [9:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return 10'($urandom_range(33, 1023));
    if (pick < 30) return 10'($urandom_range(13, 32));
    return 10'($urandom_range(1, 12));
  endfunction

  //--------------------------------------------------------------------------
  // Receiver and result checking
  //--------------------------------------------------------------------------

  // Drop ready at random; on request hold it low for a long stretch
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= OUT_IDLE_PCT);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("ERROR at %0t: result %0d %s: got %0h, want %0h",
             $realtime, n_results, what, got, want);
    mismatches++;
  endtask

  // Compare every result transfer with the oldest owed one
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind           = kind_t'(out_tuser);
      got.otp_address    = out_tdata[9:0];
      got.otp_write_data = out_tdata[25:10];
      got.counter        = out_tdata[31:26];
      got.status         = status_t'(out_tdata[34:32]);
      n_results++;
      if (replies_due.size() == 0) begin
        report_mismatch("arrived with nothing owed", out_tdata, '0);
      end else begin
        want = replies_due.pop_front();
        if (got.kind != want.kind)
          report_mismatch("kind", got.kind, want.kind);
        if (got.otp_address != want.otp_address)
          report_mismatch("otp_address", got.otp_address, want.otp_address);
        if (got.otp_write_data != want.otp_write_data)
          report_mismatch("otp_write_data", got.otp_write_data, want.otp_write_data);
        if (got.counter != want.counter)
          report_mismatch("counter", got.counter, want.counter);
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
      end
    end
  end

  // Give up when neither side has moved a transfer for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results still owed",
                 STALL_LIMIT, replies_due.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Hand-picked events on the reset slot ranges (304/24 and 328/24)
  task automatic test_directed();
    // Unsupported codes at both ends of the range
    send_event(event_of(CMD_UNSUP_LO, 1'b0, '0, '0, 1'b0));
    send_event(event_of(CMD_UNSUP_HI, 1'b1, '1, '1, 1'b1));
    // Responses with nothing in flight are dropped silently
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_MARKER, 1'b0));
    send_event(event_of(CMD_PROG_DONE, 1'b1, '0, '0, 1'b1));
    // Targets beyond the slot count, far and by one
    send_event(event_of(CMD_SET, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_event(event_of(CMD_SET, 1'b1, 32'd25, '0, 1'b0));
    // Get on a blank counter
    send_event(event_of(CMD_GET, 1'b0, '0, '0, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_EMPTY, 1'b0));
    // Set a blank counter to two; a get and a stray read land mid-way
    send_event(event_of(CMD_SET, 1'b1, 32'd2, '0, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_EMPTY, 1'b0));
    send_event(event_of(CMD_GET, 1'b0, '0, '0, 1'b0));
    send_event(event_of(CMD_PROG_DONE, 1'b0, '0, '0, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_MARKER, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_MARKER, 1'b0));
    send_event(event_of(CMD_PROG_DONE, 1'b0, '0, '0, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_MARKER, 1'b0));
    // Failed OTP read during a scan
    send_event(event_of(CMD_GET, 1'b0, '0, '0, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, 16'hFFFF, 1'b1));
    // Failed OTP program
    send_event(event_of(CMD_SET, 1'b0, 32'd1, '0, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_EMPTY, 1'b0));
    send_event(event_of(CMD_PROG_DONE, 1'b0, '0, '0, 1'b1));
    // Foreign word in the third slot
    send_event(event_of(CMD_GET, 1'b1, '0, '0, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_MARKER, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, SLOT_MARKER, 1'b0));
    send_event(event_of(CMD_RD_RESP, 1'b0, '0, 16'h1234, 1'b0));
  endtask

  // Extremes of the slot-range registers, back to reset values at the end
  task automatic test_register_sweep();
    // Secure bank disabled; non-secure runs off the top of the array
    apply_setting(10'd0, 10'd0, 10'd1023, 10'd32);
    repeat (5) run_command(5);
    // All-ones count field masks to 63 and saturates; one-slot counter
    apply_setting(10'h3FF, 10'h3FF, 10'd512, 10'd1);
    repeat (5) run_command(5);
    // One past the maximum, and the other bank disabled at address zero
    apply_setting(10'd1000, 10'd33, 10'd0, 10'd0);
    repeat (5) run_command(5);
    apply_setting(10'(SEC_FIRST_RST), 10'(SEC_COUNT_RST),
                  10'(NSEC_FIRST_RST), 10'(NSEC_COUNT_RST));
    repeat (5) run_command(5);
  endtask

  // Back-to-back transfers with neither side idling
  task automatic test_full_rate();
    fill_otp();
    steady = 1'b1;
    repeat (15) run_command(0);
    steady = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, so the block
  // backs up and stalls its input; then pause until all results are back
  task automatic test_backpressure();
    fill_otp();
    hold_req = 1'b1;
    repeat (10) run_command(5);
    wait_drained();
  endtask

  // Random commands, random slot ranges, refreshed counter contents
  task automatic test_random();
    int cmds;
    cmds = 0;
    while (n_events < TOTAL_EVENTS) begin
      if (cmds % 50 == 0)
        apply_setting(10'($urandom_range(1023)), random_count(),
                      10'($urandom_range(1023)), random_count());
      else if (cmds % 10 == 0)
        fill_otp();
      run_command(8);
      cmds++;
    end
  endtask

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    regs       = {SEC_FIRST_RST, SEC_COUNT_RST, NSEC_FIRST_RST, NSEC_COUNT_RST};
    seq_phase  = PH_IDLE;
    seq_is_set = 1'b0;
    seq_base   = '0;
    seq_count  = '0;
    seq_slot   = '0;
    seq_target = '0;
    foreach (otp_mem[i]) otp_mem[i] = SLOT_EMPTY;

    // Hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_sweep();
    test_full_rate();
    test_backpressure();
    test_random();

    wait_drained();
    if (replies_due.size() != 0)
      report_mismatch("results never arrived", 40'(replies_due.size()), '0);

    $display("Run covered %0d events, %0d answered and %0d results checked",
             n_events, n_answered, n_results);
    $display("Get/set on both banks over %0d slot-range settings, with busy, stray, "
             , n_settings, "OTP-error and security cases");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
